// File: sv/vcbg_pkg.sv
// ============================================================================
// vcbg_pkg
// Shared types and constants for the vertical color bar generator.
// ============================================================================
package vcbg_pkg;

    // Sizing
    localparam int PALETTE_ENTRIES = 32;
    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;              // holds 1..MAX_DIMENSION
    localparam int POS_W         = 12;              // column / row position
    localparam int COUNT_W       = 6;               // holds 0..PALETTE_ENTRIES
    localparam int IDX_W         = 5;               // palette address
    localparam int BIT_W         = 3;               // quotient bit select
    localparam int COLOR_W       = 8;
    localparam int RGB_W         = 3 * COLOR_W;
    localparam int PROD_W        = POS_W + COUNT_W; // x * count
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    // Register reset values
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(480);
    localparam logic [COUNT_W-1:0] COUNT_RESET  = '0;

    // Full-scale red used when no palette colors are in use
    localparam logic [COLOR_W-1:0] RED_FULL     = COLOR_W'(255);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_COLOR_COUNT  = 2'd2
    } reg_idx_t;

    // Input actions
    localparam logic ACT_PIXEL   = 1'b0;
    localparam logic ACT_PALETTE = 1'b1;

    // Input channel payload
    typedef struct packed {
        logic               action;
        logic [IDX_W-1:0]   palette_index;
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
    } in_item_t;

    // Result channel payload
    typedef struct packed {
        logic [COLOR_W-1:0] blue_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] red_out;
        logic               line_end;
        logic               frame_end;
    } out_item_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COUNT_W-1:0] count;
    } cfg_t;

    // Command passed from front to back
    typedef struct packed {
        logic               is_write;
        logic [IDX_W-1:0]   idx;
        logic [RGB_W-1:0]   rgb;
        logic [POS_W-1:0]   x;
        logic               line_end;
        logic               frame_end;
    } q_item_t;

endpackage

// File: sv/vcbg_ram.sv
// ============================================================================
// vcbg_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module vcbg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/vcbg_queue.sv
// ============================================================================
// vcbg_queue
// Two-entry command queue between the front and back parts.
// ============================================================================
module vcbg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vcbg_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output vcbg_pkg::q_item_t pop_item
);

    vcbg_pkg::q_item_t                  entry_reg [vcbg_pkg::QUEUE_DEPTH];
    logic [vcbg_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [vcbg_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [vcbg_pkg::QCNT_W-1:0]        count_reg;
    logic [vcbg_pkg::QCNT_W-1:0]        count_next;

    assign full     = (count_reg == vcbg_pkg::QCNT_W'(vcbg_pkg::QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                entry_reg[wr_ptr_reg] <= push_item;
                wr_ptr_reg            <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/vcbg_front.sv
// ============================================================================
// vcbg_front
// Accepts input items, tracks the raster position and queues commands.
// ============================================================================
module vcbg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  vcbg_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  vcbg_pkg::in_item_t s_data,
    input  logic               q_full,
    output logic               q_push,
    output vcbg_pkg::q_item_t  q_item
);

    logic [vcbg_pkg::POS_W-1:0] col_reg;
    logic [vcbg_pkg::POS_W-1:0] col_next;
    logic [vcbg_pkg::POS_W-1:0] row_reg;
    logic [vcbg_pkg::POS_W-1:0] row_next;
    logic                       last_col;
    logic                       last_row;
    logic                       pixel_acc;

    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    assign pixel_acc = q_push && (s_data.action == vcbg_pkg::ACT_PIXEL);

    // Position at or past the last column / row (covers a shrunken size)
    assign last_col = ({1'b0, col_reg} >= (cfg.width  - 1'b1));
    assign last_row = ({1'b0, row_reg} >= (cfg.height - 1'b1));

    // Command for the back part
    always_comb begin
        q_item.is_write  = (s_data.action == vcbg_pkg::ACT_PALETTE);
        q_item.idx       = s_data.palette_index;
        q_item.rgb       = {s_data.red_in, s_data.green_in, s_data.blue_in};
        q_item.x         = col_reg;
        q_item.line_end  = last_col;
        q_item.frame_end = last_col && last_row;
    end

    // Raster advance
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pixel_acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: sv/vcbg_back.sv
// ============================================================================
// vcbg_back
// Executes queued commands: palette writes, bar index division and lookup.
// ============================================================================
module vcbg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  vcbg_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  vcbg_pkg::q_item_t   q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output vcbg_pkg::out_item_t m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_PUSH
    } state_t;

    state_t                      state_reg;
    logic [vcbg_pkg::PROD_W-1:0] rem_reg;
    logic [vcbg_pkg::IDX_W-1:0]  quot_reg;
    logic [vcbg_pkg::BIT_W-1:0]  bit_reg;
    logic                        use_red_reg;
    logic                        line_end_reg;
    logic                        frame_end_reg;
    logic                        m_valid_reg;
    vcbg_pkg::out_item_t         m_data_reg;

    logic [vcbg_pkg::PROD_W-1:0] product;
    logic [vcbg_pkg::PROD_W-1:0] divisor;
    logic [vcbg_pkg::RGB_W-1:0]  ram_rdata;
    logic                        ram_we;
    logic                        ram_re;
    logic                        out_load;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign ram_we   = q_pop && q_item.is_write;
    assign ram_re   = (state_reg == S_RD);
    assign out_load = (state_reg == S_PUSH) && (!m_valid_reg || m_ready);

    // x * count, and the width aligned to the quotient bit under test
    assign product = vcbg_pkg::PROD_W'(q_item.x) * vcbg_pkg::PROD_W'(cfg.count);
    assign divisor = vcbg_pkg::PROD_W'(cfg.width) << bit_reg;

    // Palette storage
    vcbg_ram #(
        .WIDTH (vcbg_pkg::RGB_W),
        .DEPTH (vcbg_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_item.idx),
        .wdata (q_item.rgb),
        .re    (ram_re),
        .raddr (quot_reg),
        .rdata (ram_rdata)
    );

    // Sequencer: restoring division one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Output valid: set on a new result, cleared once transferred
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && !q_item.is_write) begin
                        line_end_reg  <= q_item.line_end;
                        frame_end_reg <= q_item.frame_end;
                        if (cfg.count == '0) begin
                            use_red_reg <= 1'b1;
                            state_reg   <= S_PUSH;
                        end else if ({1'b0, q_item.x} >= cfg.width) begin
                            // Past the line end: last bar
                            use_red_reg <= 1'b0;
                            quot_reg    <= vcbg_pkg::IDX_W'(cfg.count - 1'b1);
                            state_reg   <= S_RD;
                        end else begin
                            use_red_reg <= 1'b0;
                            rem_reg     <= product;
                            quot_reg    <= '0;
                            bit_reg     <= vcbg_pkg::BIT_W'(vcbg_pkg::IDX_W - 1);
                            state_reg   <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (rem_reg >= divisor) begin
                        rem_reg           <= rem_reg - divisor;
                        quot_reg[bit_reg] <= 1'b1;
                    end
                    if (bit_reg == '0) begin
                        state_reg <= S_RD;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                S_RD: begin
                    state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_load) begin
                        if (use_red_reg) begin
                            m_data_reg.red_out   <= vcbg_pkg::RED_FULL;
                            m_data_reg.green_out <= '0;
                            m_data_reg.blue_out  <= '0;
                        end else begin
                            m_data_reg.red_out   <= ram_rdata[23:16];
                            m_data_reg.green_out <= ram_rdata[15:8];
                            m_data_reg.blue_out  <= ram_rdata[7:0];
                        end
                        m_data_reg.line_end  <= line_end_reg;
                        m_data_reg.frame_end <= frame_end_reg;
                        state_reg            <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/vertical_color_bar_generator.sv
// ============================================================================
// vertical_color_bar_generator
// Raster-order vertical color bar test pattern with a writable palette.
// ============================================================================
// Usage:
//   s_* channel (valid/ready): action 0 asks for the next pixel, action 1
//   writes palette_index with red/green/blue and gives no result.
//   m_* channel (valid/ready): one pixel per pixel request, in order, with
//   line_end / frame_end marking the last pixel of a line / frame.
//   cfg_we/cfg_index/cfg_wdata: width, height and color count; write only
//   while the block is idle.
// Sequencing:
//   The back part handles one command at a time: a pixel request passes
//   through the pop, the 5-step bar index division, the palette read and
//   the output load. With color count zero it goes from the pop straight
//   to the output load; a column left past a shrunken width skips the
//   division. A palette write is done at the pop.
//   A 2-entry queue lets s_ready stay high while the back part is busy.
// Reset: counters return to the top-left pixel, registers to 640 x 480 with
//   solid red; palette contents are undefined until written.
// Stall: with m_ready low the result is held in the output register; the
//   back part then stops and the queue fills, after which s_ready drops.
// ============================================================================
module vertical_color_bar_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vcbg_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vcbg_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [vcbg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vcbg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [vcbg_pkg::DIM_W-1:0]   width_reg;
    logic [vcbg_pkg::DIM_W-1:0]   height_reg;
    logic [vcbg_pkg::COUNT_W-1:0] count_reg;
    vcbg_pkg::cfg_t               cfg;

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    vcbg_pkg::q_item_t q_in;
    vcbg_pkg::q_item_t q_out;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= vcbg_pkg::WIDTH_RESET;
            height_reg <= vcbg_pkg::HEIGHT_RESET;
            count_reg  <= vcbg_pkg::COUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vcbg_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                vcbg_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                vcbg_pkg::REG_COLOR_COUNT:
                    count_reg <= cfg_wdata[vcbg_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp to legal ranges: zero size reads as 1, oversize saturates
    always_comb begin
        if (width_reg == '0) begin
            cfg.width = vcbg_pkg::DIM_W'(1);
        end else if (width_reg > vcbg_pkg::DIM_W'(vcbg_pkg::MAX_DIMENSION)) begin
            cfg.width = vcbg_pkg::DIM_W'(vcbg_pkg::MAX_DIMENSION);
        end else begin
            cfg.width = width_reg;
        end
        if (height_reg == '0) begin
            cfg.height = vcbg_pkg::DIM_W'(1);
        end else if (height_reg > vcbg_pkg::DIM_W'(vcbg_pkg::MAX_DIMENSION)) begin
            cfg.height = vcbg_pkg::DIM_W'(vcbg_pkg::MAX_DIMENSION);
        end else begin
            cfg.height = height_reg;
        end
        if (count_reg > vcbg_pkg::COUNT_W'(vcbg_pkg::PALETTE_ENTRIES)) begin
            cfg.count = vcbg_pkg::COUNT_W'(vcbg_pkg::PALETTE_ENTRIES);
        end else begin
            cfg.count = count_reg;
        end
    end

    vcbg_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    vcbg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out)
    );

    vcbg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: sv/vcbg_checker.sv
// ============================================================================
// vcbg_checker
// Port-level checks for the vertical color bar generator.
// ============================================================================
module vcbg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input vcbg_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input vcbg_pkg::out_item_t m_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // End of frame is always also end of line
    a_frame_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.frame_end || m_data.line_end))
        else $error("frame_end without line_end");

    // Nothing is presented right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A waiting input keeps its payload until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while waiting");

endmodule

bind vertical_color_bar_generator vcbg_checker u_vcbg_checker (.*);
